[hdl/life_automaton_generation_step_top_assert.svh]
// ----------------------------------------------------------------------------
// Life generation step: assertion macros
// Shorthands for the concurrent checks at the end of the top level. They use
// the top level's clock and reset names.
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_GENERATION_STEP_TOP_ASSERT_SVH
`define LIFE_AUTOMATON_GENERATION_STEP_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LSTEP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LSTEP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/lstep_pkg.sv]
// ----------------------------------------------------------------------------
// Life generation step: shared package
// Payload types, register indexes and rule constants used across the block.
// ----------------------------------------------------------------------------
package lstep_pkg;

   localparam int ROW_W        = 10;
   localparam int COL_W        = 10;
   localparam int SIZE_W       = 11;
   localparam int CSR_INDEX_W  = 4;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 1024;
   localparam int RESET_SIZE         = 1024;
   localparam int MIN_SIZE           = 3;

   // B3/S23 rule
   localparam int BIRTH_COUNT  = 3;
   localparam int SURVIVE_MIN  = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_GRID_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_HEIGHT = CSR_INDEX_W'(1);

   typedef struct packed {
      logic mode;
      logic cell_alive;
   } req_type;

   typedef struct packed {
      logic             next_alive;
      logic [ROW_W-1:0] cell_row;
      logic [COL_W-1:0] cell_col;
      logic             frame_last;
   } rsp_type;

   // One window column plus the position flags of the cell it centres on.
   typedef struct packed {
      logic             up;
      logic             mid;
      logic             alive;
      logic             at_left;
      logic             at_right;
      logic             at_top;
      logic             at_bottom;
      logic             has_result;
      logic             last;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } lstep_cell_type;

endpackage

[hdl/lstep_front.sv]
// ----------------------------------------------------------------------------
// Life generation step: front end
// Size registers, raster position counters, the two line stores and the
// input register that feeds the stencil.
// ----------------------------------------------------------------------------
module lstep_front #(
   parameter int MAX_WIDTH  = lstep_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = lstep_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [lstep_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lstep_pkg::SIZE_W-1:0]        csr_wdata,
   input  logic                                req_accept,
   input  lstep_pkg::req_type                  req_payload,
   input  logic                                adv,
   output logic                                restart,
   output logic                                s1_valid,
   output lstep_pkg::lstep_cell_type           s1_cell
);

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT + 2);
   localparam int SWW = (WW > lstep_pkg::SIZE_W) ? WW : lstep_pkg::SIZE_W;
   localparam int SHW = (HW > lstep_pkg::SIZE_W) ? HW : lstep_pkg::SIZE_W;
   localparam int W_RST = (lstep_pkg::RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH
                                                              : lstep_pkg::RESET_SIZE;
   localparam int H_RST = (lstep_pkg::RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT
                                                               : lstep_pkg::RESET_SIZE;

   logic [WW-1:0]  w_ff, w_in;
   logic [HW-1:0]  h_ff, h_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic           s1_valid_ff, s1_valid_in;
   logic [CW-1:0]  s1_col_ff;
   logic [1:0]     rd_ff;
   lstep_pkg::lstep_cell_type s1_ff, s1_in;

   // bit 0: the row two above the arriving one, bit 1: the row just above
   logic [1:0]     line_mem [MAX_WIDTH];

   logic [SWW-1:0] wdata_w;
   logic [SHW-1:0] wdata_h;
   logic           wr_width, wr_height;
   logic           col_nz, row_ok, wrap;
   logic [CW-1:0]  w_m1, cc;
   logic [RW-1:0]  h_r, cr;

   // Size register writes: decode and clamp to the legal range.
   always_comb begin
      wr_width  = 1'b0;
      wr_height = 1'b0;
      unique case (csr_index)
         lstep_pkg::REG_GRID_WIDTH:  wr_width  = csr_valid;
         lstep_pkg::REG_GRID_HEIGHT: wr_height = csr_valid;
         default: ;
      endcase

      wdata_w = SWW'(csr_wdata);
      wdata_h = SHW'(csr_wdata);
      if (wdata_w < SWW'(lstep_pkg::MIN_SIZE)) begin
         w_in = WW'(lstep_pkg::MIN_SIZE);
      end else if (wdata_w > SWW'(MAX_WIDTH)) begin
         w_in = WW'(MAX_WIDTH);
      end else begin
         w_in = WW'(wdata_w);
      end
      if (wdata_h < SHW'(lstep_pkg::MIN_SIZE)) begin
         h_in = HW'(lstep_pkg::MIN_SIZE);
      end else if (wdata_h > SHW'(MAX_HEIGHT)) begin
         h_in = HW'(MAX_HEIGHT);
      end else begin
         h_in = HW'(wdata_h);
      end
   end

   assign restart = wr_width | wr_height;

   // Position of the window centre relative to the arriving cell: one row up and one
   // column back, or the last column two rows up when the arriving cell opens a row.
   always_comb begin
      col_nz = (col_ff != '0);
      w_m1   = CW'(w_ff - WW'(1));
      h_r    = RW'(h_ff);
      cr     = row_ff - (col_nz ? RW'(1) : RW'(2));
      cc     = col_nz ? (col_ff - CW'(1)) : w_m1;
      row_ok = col_nz ? (row_ff >= RW'(1)) : (row_ff >= RW'(2));
      wrap   = (col_ff == w_m1);

      s1_in            = '0;
      s1_in.alive      = !req_payload.mode && (row_ff < h_r) && req_payload.cell_alive;
      s1_in.at_left    = (cc == '0);
      s1_in.at_right   = (cc == w_m1);
      s1_in.at_top     = (cr == '0);
      s1_in.at_bottom  = (cr == h_r - RW'(1));
      s1_in.has_result = row_ok && (cr < h_r);
      // The final cell is centred when the arriving item opens row height+1.
      s1_in.last       = !col_nz && (row_ff == h_r + RW'(1));
      s1_in.row        = lstep_pkg::ROW_W'(cr);
      s1_in.col        = lstep_pkg::COL_W'(cc);

      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (s1_in.last) begin
            col_in = '0;
            row_in = '0;
         end else if (wrap) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end

      s1_valid_in = adv ? req_accept : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff        <= WW'(W_RST);
         h_ff        <= HW'(H_RST);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (wr_width) begin
            w_ff <= w_in;
         end
         if (wr_height) begin
            h_ff <= h_in;
         end
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff     <= s1_in;
         s1_col_ff <= col_ff;
      end
   end

   // Line stores: read at the arriving column, written back as the beat
   // leaves the input register.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_ff <= line_mem[col_ff];
      end
      if (s1_valid_ff && adv) begin
         line_mem[s1_col_ff] <= {s1_ff.alive, rd_ff[1]};
      end
   end

   always_comb begin
      s1_cell     = s1_ff;
      s1_cell.up  = rd_ff[0];
      s1_cell.mid = rd_ff[1];
   end

   assign s1_valid = s1_valid_ff;

endmodule

[hdl/lstep_stencil.sv]
// ----------------------------------------------------------------------------
// Life generation step: stencil
// Shifts a 3x3 window, counts live neighbours inside the grid, applies the
// B3/S23 rule and holds the result beat for the output channel.
// ----------------------------------------------------------------------------
module lstep_stencil (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       restart,
   input  logic                       s1_valid,
   input  lstep_pkg::lstep_cell_type  s1_cell,
   input  logic                       rsp_stall,
   output logic                       adv,
   output logic                       rsp_valid,
   output lstep_pkg::rsp_type         rsp_payload
);

   localparam logic [8:0] NEIGH_MASK  = 9'h1EF;
   localparam logic [8:0] LEFT_MASK   = 9'h007;
   localparam logic [8:0] RIGHT_MASK  = 9'h1C0;
   localparam logic [8:0] TOP_MASK    = 9'h049;
   localparam logic [8:0] BOTTOM_MASK = 9'h124;

   logic [8:0]          window_ff, window_in;
   logic                rsp_valid_ff, rsp_valid_in;
   lstep_pkg::rsp_type  rsp_ff, rsp_in;
   logic [8:0]          mask, masked;
   logic [3:0]          count;

   assign adv = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      // Oldest column in bits 2:0, newest in bits 8:6; bit 4 is the centre.
      window_in = {s1_cell.alive, s1_cell.mid, s1_cell.up, window_ff[8:3]};

      mask = NEIGH_MASK;
      if (s1_cell.at_left) begin
         mask = mask & ~LEFT_MASK;
      end
      if (s1_cell.at_right) begin
         mask = mask & ~RIGHT_MASK;
      end
      if (s1_cell.at_top) begin
         mask = mask & ~TOP_MASK;
      end
      if (s1_cell.at_bottom) begin
         mask = mask & ~BOTTOM_MASK;
      end
      masked = window_in & mask;

      count = '0;
      for (int i = 0; i < 9; i++) begin
         count = count + 4'(masked[i]);
      end

      rsp_in.cell_row   = s1_cell.row;
      rsp_in.cell_col   = s1_cell.col;
      rsp_in.frame_last = s1_cell.last;
      if (window_in[4]) begin
         rsp_in.next_alive = (count == 4'(lstep_pkg::SURVIVE_MIN)) ||
                             (count == 4'(lstep_pkg::BIRTH_COUNT));
      end else begin
         rsp_in.next_alive = (count == 4'(lstep_pkg::BIRTH_COUNT));
      end

      rsp_valid_in = adv ? (s1_valid && s1_cell.has_result) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (restart) begin
            window_ff <= '0;
         end else if (adv && s1_valid) begin
            window_ff <= window_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid && s1_cell.has_result) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[hdl/life_automaton_generation_step_top.sv]
// ----------------------------------------------------------------------------
// Life generation step: top level
// One generation of the B3/S23 automaton over a streamed raster grid.
// ----------------------------------------------------------------------------
// The current generation arrives on the req_ channel one cell per beat in
// raster order, followed by width+1 flush beats. From the beat at stream
// position width+1 onward, each accepted beat yields one rsp_ beat with the
// next state of the cell width+1 positions earlier, its row and column; the
// final cell is marked with frame_last, after which the next beat starts a
// new frame at cell (0,0).
// The block takes one beat per clock while no result is held by rsp_stall. A result
// passes through the input register, where the line store is read, and then
// through the stencil's output register. The line store, read and written
// once per cycle, sets this rate.
// The user must write grid sizes on the csr_ channel only while the block is
// idle; the block itself does not enforce it. Each write restarts the frame.
// Reset sets both sizes to 1024 (or the maximum, if smaller) and clears the
// position and window; the line stores need no clearing. While rsp_stall
// holds a result, req_stall is raised and no new beat enters.
// ----------------------------------------------------------------------------
module life_automaton_generation_step_top #(
   parameter int MAX_WIDTH  = lstep_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = lstep_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lstep_pkg::req_type                req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lstep_pkg::rsp_type                rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lstep_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lstep_pkg::SIZE_W-1:0]      csr_wdata
);

`include "life_automaton_generation_step_top_assert.svh"

   logic                      adv;
   logic                      req_accept;
   logic                      restart;
   logic                      s1_valid;
   lstep_pkg::lstep_cell_type s1_cell;

   assign csr_ready  = 1'b1;
   assign req_stall  = !adv;
   assign req_accept = req_valid && adv;

   lstep_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_accept  (req_accept),
      .req_payload (req_payload),
      .adv         (adv),
      .restart     (restart),
      .s1_valid    (s1_valid),
      .s1_cell     (s1_cell)
   );

   lstep_stencil u_stencil (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .s1_valid    (s1_valid),
      .s1_cell     (s1_cell),
      .rsp_stall   (rsp_stall),
      .adv         (adv),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // A held result must block the input side.
   `LSTEP_ASSERT_SAME(a_stall_back, rsp_valid && rsp_stall, req_stall, "input not stalled behind a held result")
   // An accepted beat always lands in the input register.
   `LSTEP_ASSERT_NEXT(a_accept_fill, req_valid && !req_stall, s1_valid, "accepted beat lost before the stencil")
   // A fresh result can only come from an accepted beat that has passed the input register.
   `LSTEP_ASSERT_SAME(a_result_source, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "result without a source beat")
   // A result is only withdrawn once it has been taken.
   `LSTEP_ASSERT_SAME(a_result_kept, $fell(rsp_valid), $past(!rsp_stall), "result dropped while stalled")

endmodule

[verif/tb_life_automaton_generation_step_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life generation step: testbench
// Streams B3/S23 generations through the block and checks every result beat
// against the script or a testbench line-buffered stencil. A short scripted
// blinker frame comes first, then random frames at small sizes, noisy and cut
// frames, saturated size writes, a short frame at saturated full width and a
// cut frame at saturated full height, under three patterns of back-pressure.
// ----------------------------------------------------------------------------
module tb_life_automaton_generation_step_top;

   localparam int GRID_MAX_W   = lstep_pkg::MAX_WIDTH_DEFAULT;
   localparam int GRID_MAX_H   = lstep_pkg::MAX_HEIGHT_DEFAULT;
   localparam int DRAIN_CYCLES = 8;
   localparam int RESET_CYCLES = 11;
   localparam int PHASE_BEATS  = 250;
   localparam int WIDE_CUT     = 60;
   localparam int TALL_CUT     = 180;

   typedef struct packed {
      logic                              is_write;
      logic [lstep_pkg::CSR_INDEX_W-1:0] index;
      logic [lstep_pkg::SIZE_W-1:0]      data;
      lstep_pkg::req_type                beat;
      logic                              typed;
      lstep_pkg::rsp_type                want;
   } script_row_type;

   logic                              clock       = 1'b0;
   logic                              reset       = 1'b1;
   logic                              req_valid   = 1'b0;
   logic                              req_stall;
   lstep_pkg::req_type                req_payload = '0;
   logic                              rsp_valid;
   logic                              rsp_stall   = 1'b0;
   lstep_pkg::rsp_type                rsp_payload;
   logic                              csr_valid   = 1'b0;
   logic                              csr_ready;
   logic [lstep_pkg::CSR_INDEX_W-1:0] csr_index   = '0;
   logic [lstep_pkg::SIZE_W-1:0]      csr_wdata   = '0;

   // Scripted expectation travelling alongside the beat on the wire.
   logic                   beat_typed  = 1'b0;
   lstep_pkg::rsp_type     beat_want   = '0;

   int unsigned send_idle_pct = 30;
   int unsigned recv_idle_pct = 76;

   // Stencil state mirrored in the testbench.
   logic [lstep_pkg::SIZE_W-1:0] width_reg  = lstep_pkg::SIZE_W'(lstep_pkg::RESET_SIZE);
   logic [lstep_pkg::SIZE_W-1:0] height_reg = lstep_pkg::SIZE_W'(lstep_pkg::RESET_SIZE);
   bit                row_two_up [GRID_MAX_W];
   bit                row_one_up [GRID_MAX_W];
   logic [8:0]        stencil    = '0;
   int unsigned       stream_pos = 0;
   int unsigned       arr_col    = 0;
   int unsigned       arr_row    = 0;

   lstep_pkg::rsp_type pending_cells [$];
   script_row_type     script [$];

   int unsigned beats_sent      = 0;
   int unsigned beats_taken     = 0;
   int unsigned results_checked = 0;
   int unsigned generations     = 0;
   int unsigned live_next       = 0;
   int unsigned failures        = 0;

   life_automaton_generation_step_top #(
      .MAX_WIDTH  (GRID_MAX_W),
      .MAX_HEIGHT (GRID_MAX_H)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   function automatic int unsigned clamp_size(logic [lstep_pkg::SIZE_W-1:0] v,
                                              int unsigned hi);
      if (v < lstep_pkg::MIN_SIZE) return unsigned'(lstep_pkg::MIN_SIZE);
      if (v > hi) return hi;
      return 32'(v);
   endfunction

   function automatic void restart_frame();
      stencil    = '0;
      stream_pos = 0;
      arr_col    = 0;
      arr_row    = 0;
   endfunction

   function automatic void note_expected(lstep_pkg::rsp_type r);
      pending_cells.insert(pending_cells.size(), r);
   endfunction

   function automatic void add_row(script_row_type r);
      script.insert(script.size(), r);
   endfunction

   function automatic void apply_csr(logic [lstep_pkg::CSR_INDEX_W-1:0] idx,
                                     logic [lstep_pkg::SIZE_W-1:0] data);
      if (idx == lstep_pkg::REG_GRID_WIDTH) begin
         width_reg = data;
         restart_frame();
      end else if (idx == lstep_pkg::REG_GRID_HEIGHT) begin
         height_reg = data;
         restart_frame();
      end
   endfunction

   // Shifts one beat into the window and returns 1 when a cell's next state
   // falls out of it.
   function automatic logic advance_stencil(lstep_pkg::req_type beat,
                                            output lstep_pkg::rsp_type res);
      int unsigned w, h, col, n;
      logic        v, up, mid, centre;
      logic [8:0]  mask;
      int          cr, cc;
      w   = clamp_size(width_reg, GRID_MAX_W);
      h   = clamp_size(height_reg, GRID_MAX_H);
      col = arr_col % GRID_MAX_W;
      v   = (beat.mode == 1'b0 && arr_row < h) ? beat.cell_alive : 1'b0;
      up  = row_two_up[col];
      mid = row_one_up[col];
      row_two_up[col] = mid;
      row_one_up[col] = v;
      stencil = {v, mid, up, stencil[8:3]};
      res = '0;
      if (col >= 1) begin
         cr = int'(arr_row) - 1;
         cc = int'(col) - 1;
      end else begin
         cr = int'(arr_row) - 2;
         cc = int'(w) - 1;
      end
      if (stream_pos >= w + 1 && cr >= 0 && cr < int'(h)) begin
         // Neighbours beyond the grid edge are dead.
         mask = 9'h1EF;
         if (cc < 1) mask = mask & ~9'h007;
         if (cc + 1 >= int'(w)) mask = mask & ~9'h1C0;
         if (cr < 1) mask = mask & ~9'h049;
         if (cr + 1 >= int'(h)) mask = mask & ~9'h124;
         n      = $countones(stencil & mask);
         centre = stencil[4];
         res.next_alive = centre ? (n == lstep_pkg::SURVIVE_MIN ||
                                    n == lstep_pkg::BIRTH_COUNT)
                                 : (n == lstep_pkg::BIRTH_COUNT);
         res.cell_row   = cr[lstep_pkg::ROW_W-1:0];
         res.cell_col   = cc[lstep_pkg::COL_W-1:0];
         res.frame_last = (cr == int'(h) - 1) && (cc == int'(w) - 1);
         if (res.frame_last) begin
            restart_frame();
            return 1'b1;
         end
         stream_pos++;
         if (arr_col + 1 >= w) begin
            arr_col = 0;
            arr_row++;
         end else begin
            arr_col++;
         end
         return 1'b1;
      end
      stream_pos++;
      if (arr_col + 1 >= w) begin
         arr_col = 0;
         arr_row++;
      end else begin
         arr_col++;
      end
      return 1'b0;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      lstep_pkg::rsp_type predicted;
      lstep_pkg::rsp_type want;
      logic               produced;
      if (!reset) begin
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            produced = advance_stencil(req_payload, predicted);
            beats_taken++;
            if (beat_typed) note_expected(beat_want);
            else if (produced) note_expected(predicted);
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (pending_cells.size() == 0) begin
               $error("result beat with nothing expected: row %0d col %0d",
                      rsp_payload.cell_row, rsp_payload.cell_col);
               failures++;
            end else begin
               want = pending_cells.pop_front();
               check_field("next_alive", 32'(want.next_alive),
                           32'(rsp_payload.next_alive));
               check_field("cell_row", 32'(want.cell_row), 32'(rsp_payload.cell_row));
               check_field("cell_col", 32'(want.cell_col), 32'(rsp_payload.cell_col));
               check_field("frame_last", 32'(want.frame_last),
                           32'(rsp_payload.frame_last));
               results_checked++;
               if (want.frame_last) generations++;
               if (want.next_alive) live_next++;
            end
         end
      end
   end

   task automatic send_beat(lstep_pkg::req_type beat, logic typed, lstep_pkg::rsp_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      beat_typed  <= typed;
      beat_want   <= want;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      beats_sent++;
   endtask

   task automatic write_csr(logic [lstep_pkg::CSR_INDEX_W-1:0] idx,
                            logic [lstep_pkg::SIZE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits for the last result, then idles with no beat offered to clear the
   // pipeline.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [lstep_pkg::SIZE_W-1:0] w_data,
                            logic [lstep_pkg::SIZE_W-1:0] h_data);
      if ($urandom_range(0, 1)) begin
         write_csr(lstep_pkg::REG_GRID_WIDTH, w_data);
         write_csr(lstep_pkg::REG_GRID_HEIGHT, h_data);
      end else begin
         write_csr(lstep_pkg::REG_GRID_HEIGHT, h_data);
         write_csr(lstep_pkg::REG_GRID_WIDTH, w_data);
      end
   endtask

   // One generation at the current size, cut short after cut_at beats.
   task automatic send_frame(int unsigned density, logic noisy, int unsigned cut_at);
      int unsigned        w, h, cells, total, i;
      lstep_pkg::req_type beat;
      w     = clamp_size(width_reg, GRID_MAX_W);
      h     = clamp_size(height_reg, GRID_MAX_H);
      cells = w * h;
      total = cells + w + 1;
      for (i = 0; i < total && i < cut_at; i++) begin
         if (i < cells) begin
            beat.mode       = noisy && ($urandom_range(0, 99) < 12);
            beat.cell_alive = ($urandom_range(0, 99) < density);
         end else begin
            beat.mode       = noisy ? 1'($urandom_range(0, 1)) : 1'b1;
            beat.cell_alive = 1'($urandom_range(0, 1));
         end
         send_beat(beat, 1'b0, '0);
      end
   endtask

   function automatic logic [lstep_pkg::SIZE_W-1:0] pick_size();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return lstep_pkg::SIZE_W'($urandom_range(0, lstep_pkg::MIN_SIZE - 1));
      if (roll < 20) return lstep_pkg::SIZE_W'($urandom_range(13, 24));
      return lstep_pkg::SIZE_W'($urandom_range(lstep_pkg::MIN_SIZE, 12));
   endfunction

   task automatic run_random_phase(int unsigned budget);
      int unsigned start, frames, density, f, roll;
      logic        noisy;
      start = beats_sent;
      while (beats_sent - start < budget) begin
         settle();
         roll = $urandom_range(0, 99);
         if (roll < 15) write_csr(lstep_pkg::REG_GRID_WIDTH, pick_size());
         else if (roll < 25) write_csr(lstep_pkg::REG_GRID_HEIGHT, pick_size());
         else configure(pick_size(), pick_size());
         // Indexes past the last register must be ignored.
         if ($urandom_range(0, 99) < 15)
            write_csr(lstep_pkg::CSR_INDEX_W'($urandom_range(lstep_pkg::REG_GRID_HEIGHT + 1,
                                                             2**lstep_pkg::CSR_INDEX_W - 1)),
                      lstep_pkg::SIZE_W'($urandom));
         frames = $urandom_range(1, 3);
         for (f = 0; f < frames && beats_sent - start < budget; f++) begin
            case ($urandom_range(0, 4))
               0: density = 5;
               1: density = 30;
               2: density = 45;
               3: density = 70;
               default: density = 95;
            endcase
            noisy = ($urandom_range(0, 99) < 15);
            if (f == frames - 1 && $urandom_range(0, 99) < 12)
               send_frame(density, noisy, $urandom_range(1, 60));
            else
               send_frame(density, noisy, 32'hFFFF_FFFF);
         end
      end
      settle();
   endtask

   task automatic script_write(logic [lstep_pkg::CSR_INDEX_W-1:0] idx,
                               logic [lstep_pkg::SIZE_W-1:0] data);
      script_row_type row;
      row          = '0;
      row.is_write = 1'b1;
      row.index    = idx;
      row.data     = data;
      add_row(row);
   endtask

   task automatic script_beat(logic mode, logic alive);
      script_row_type row;
      row                 = '0;
      row.beat.mode       = mode;
      row.beat.cell_alive = alive;
      add_row(row);
   endtask

   task automatic script_checked(logic mode, logic alive, logic next, int unsigned r,
                                 int unsigned c, logic last);
      script_row_type row;
      row                 = '0;
      row.beat.mode       = mode;
      row.beat.cell_alive = alive;
      row.typed           = 1'b1;
      row.want.next_alive = next;
      row.want.cell_row   = lstep_pkg::ROW_W'(r);
      row.want.cell_col   = lstep_pkg::COL_W'(c);
      row.want.frame_last = last;
      add_row(row);
   endtask

   initial begin : watchdog
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      script_row_type row;
      int unsigned    guard;

      // Sizes below the minimum saturate to a 3x3 grid. A vertical blinker
      // turns horizontal; the beat after the grid is a live cell, which must
      // be taken as a flush.
      script_write(lstep_pkg::REG_GRID_WIDTH, lstep_pkg::SIZE_W'(0));
      script_write(lstep_pkg::REG_GRID_HEIGHT, lstep_pkg::SIZE_W'(2));
      script_beat(1'b0, 1'b0);
      script_beat(1'b0, 1'b1);
      script_beat(1'b0, 1'b0);
      script_beat(1'b0, 1'b0);
      script_checked(1'b0, 1'b1, 1'b0, 0, 0, 1'b0);
      script_checked(1'b0, 1'b0, 1'b0, 0, 1, 1'b0);
      script_checked(1'b0, 1'b0, 1'b0, 0, 2, 1'b0);
      script_checked(1'b0, 1'b1, 1'b1, 1, 0, 1'b0);
      script_checked(1'b0, 1'b0, 1'b1, 1, 1, 1'b0);
      script_checked(1'b0, 1'b1, 1'b1, 1, 2, 1'b0);
      script_checked(1'b1, 1'b1, 1'b0, 2, 0, 1'b0);
      script_checked(1'b1, 1'b0, 1'b0, 2, 1, 1'b0);
      script_checked(1'b1, 1'b1, 1'b0, 2, 2, 1'b1);
      // Next frame starts on its own: a full grid with a flush in the centre.
      script_beat(1'b0, 1'b1);
      script_beat(1'b0, 1'b1);
      script_beat(1'b0, 1'b1);
      script_beat(1'b0, 1'b1);
      script_beat(1'b1, 1'b1);
      script_beat(1'b0, 1'b1);
      script_beat(1'b0, 1'b1);
      script_beat(1'b0, 1'b1);
      script_beat(1'b0, 1'b1);
      script_beat(1'b1, 1'b0);
      script_beat(1'b1, 1'b1);
      script_beat(1'b0, 1'b0);
      script_beat(1'b1, 1'b1);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         row = script[i];
         if (row.is_write) write_csr(row.index, row.data);
         else send_beat(row.beat, row.typed, row.want);
      end
      settle();
      run_random_phase(PHASE_BEATS);

      send_idle_pct <= 76;
      recv_idle_pct <= 30;
      run_random_phase(PHASE_BEATS);
      // A width past the maximum saturates to it, so the short frame that
      // follows must yield no result at all.
      configure({lstep_pkg::SIZE_W{1'b1}}, lstep_pkg::SIZE_W'(0));
      send_frame(40, 1'b0, WIDE_CUT);
      settle();

      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      run_random_phase(PHASE_BEATS);
      configure(lstep_pkg::SIZE_W'(2), {lstep_pkg::SIZE_W{1'b1}});
      send_frame(40, 1'b0, TALL_CUT);

      req_valid <= 1'b0;
      guard = 0;
      while (pending_cells.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_cells.size() != 0) begin
         $error("%0d result beats never arrived", pending_cells.size());
         failures++;
      end

      $display("Ran %0d input beats through scripted, random, cut and saturated-size frames,",
               beats_taken);
      $display("comparing %0d results over %0d whole generations (%0d cells alive next).",
               results_checked, generations, live_next);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[life_automaton_generation_step_top.f]
+incdir+hdl
hdl/lstep_pkg.sv
hdl/lstep_front.sv
hdl/lstep_stencil.sv
hdl/life_automaton_generation_step_top.sv
verif/tb_life_automaton_generation_step_top.sv
